FILE: rtl/stb_pkg.sv
package stb_pkg;

  localparam int DEF_NUM_TIMERS = 8;
  localparam int MAX_NUM_TIMERS = 64;

  localparam int CMD_W    = 3;
  localparam int ID_W     = 8;
  localparam int PERIOD_W = 32;
  localparam int RUN_W    = 31;

  localparam logic [RUN_W-1:0] RUN_WRAP = 31'h7FFF_FFFF;

  // APB register map: one register, index taken from paddr[ADDR_W-1:2]
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_TICK_ENABLE = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_ONESHOT = 3'd1,
    CMD_AUTO    = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_CHECK   = 3'd4
  } stb_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_WB
  } stb_state_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] remaining;
    logic [PERIOD_W-1:0] reload_value;
    logic                done_flag;
    logic                auto_reload;
  } stb_entry_t;

  // memory access from the sequencer; address travels separately (parameter width)
  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    stb_entry_t wdata;
  } stb_mem_req_t;

endpackage

FILE: rtl/stb_regs.sv
module stb_regs
  import stb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic              tick_enable
);

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_TICK_ENABLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_enable <= 1'b1;
    end else if (wr_hit) begin
      tick_enable <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1:2] == REG_TICK_ENABLE) begin
      prdata = {31'd0, tick_enable};
    end
  end

endmodule

FILE: rtl/stb_mem.sv
module stb_mem
  import stb_pkg::*;
#(
  parameter int NUM_TIMERS = DEF_NUM_TIMERS,
  parameter int IDX_W      = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  stb_mem_req_t     req,
  input  logic [IDX_W-1:0] addr,
  output stb_entry_t       rdata
);

  stb_entry_t              mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]   vld;
  stb_entry_t              q;
  logic                    q_vld;

  // entries never written since reset read as all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.wr_en) begin
      vld[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      q     <= mem[addr];
      q_vld <= vld[addr];
    end
  end

  assign rdata = q_vld ? q : '0;

endmodule

FILE: rtl/stb_ctrl.sv
module stb_ctrl
  import stb_pkg::*;
#(
  parameter int NUM_TIMERS = DEF_NUM_TIMERS,
  parameter int IDX_W      = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick_enable,
  input  logic                start,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [ID_W-1:0]     timer_id,
  input  logic [PERIOD_W-1:0] period,
  output logic                busy,
  output logic                done,
  output logic                expired,
  output logic                id_error,
  output logic [RUN_W-1:0]    run_time,
  output stb_mem_req_t        mem_req,
  output logic [IDX_W-1:0]    mem_addr,
  input  stb_entry_t          mem_rdata
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  stb_state_t          state, state_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [CMD_W-1:0]    cmd_q, cmd_q_next;
  logic [PERIOD_W-1:0] period_q, period_q_next;
  logic [RUN_W-1:0]    run_ms, run_ms_next;
  logic                done_next, expired_next, id_error_next;
  logic                id_bad;
  logic [RUN_W-1:0]    run_inc;
  logic [PERIOD_W-1:0] rem_dec;
  stb_entry_t          ent;

  assign id_bad   = {1'b0, timer_id} >= (ID_W + 1)'(NUM_TIMERS);
  assign run_inc  = run_ms + 1'b1;
  assign rem_dec  = mem_rdata.remaining - 1'b1;
  assign busy     = (state != ST_IDLE);
  assign run_time = run_ms;
  assign mem_addr = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      idx      <= '0;
      run_ms   <= '0;
      done     <= 1'b0;
      expired  <= 1'b0;
      id_error <= 1'b0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      run_ms   <= run_ms_next;
      done     <= done_next;
      expired  <= expired_next;
      id_error <= id_error_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q    <= cmd_q_next;
    period_q <= period_q_next;
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    cmd_q_next    = cmd_q;
    period_q_next = period_q;
    run_ms_next   = run_ms;
    done_next     = 1'b0;
    expired_next  = expired;
    id_error_next = id_error;
    mem_req       = '0;
    ent           = mem_rdata;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd_q_next    = cmd;
          period_q_next = period;
          expired_next  = 1'b0;
          id_error_next = 1'b0;
          case (cmd) inside
            CMD_TICK: begin
              if (tick_enable) begin
                idx_next   = '0;
                state_next = ST_RD;
              end else begin
                done_next = 1'b1;
              end
            end
            CMD_ONESHOT, CMD_AUTO, CMD_STOP, CMD_CHECK: begin
              if (id_bad) begin
                id_error_next = 1'b1;
                done_next     = 1'b1;
              end else begin
                idx_next   = timer_id[IDX_W-1:0];
                state_next = ST_RD;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      ST_RD: begin
        mem_req.rd_en = 1'b1;
        state_next    = ST_WB;
      end

      ST_WB: begin
        case (cmd_q) inside
          CMD_TICK: begin
            if (mem_rdata.remaining != '0) begin
              ent.remaining = rem_dec;
              if (rem_dec == '0) begin
                ent.done_flag = 1'b1;
                if (mem_rdata.auto_reload) begin
                  ent.remaining = mem_rdata.reload_value;
                end
              end
            end
          end
          CMD_ONESHOT, CMD_AUTO: begin
            ent.remaining    = period_q;
            ent.reload_value = period_q;
            ent.done_flag    = 1'b0;
            ent.auto_reload  = (cmd_q == CMD_AUTO);
          end
          CMD_STOP: begin
            ent.remaining   = '0;
            ent.done_flag   = 1'b0;
            ent.auto_reload = 1'b0;
          end
          CMD_CHECK: begin
            ent.done_flag = 1'b0;
            expired_next  = mem_rdata.done_flag;
          end
          default: begin
          end
        endcase
        mem_req.wr_en = 1'b1;
        mem_req.wdata = ent;

        if (cmd_q == CMD_TICK && idx != LAST_IDX) begin
          idx_next   = idx + 1'b1;
          state_next = ST_RD;
        end else begin
          if (cmd_q == CMD_TICK) begin
            run_ms_next = (run_inc == RUN_WRAP) ? '0 : run_inc;
          end
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/soft_timer_bank.sv
// Bank of NUM_TIMERS down-counting timers with a 31-bit run-time counter. A request is
// taken when start is high and busy is low. Its single result is marked by done for exactly
// one cycle and must be captured then (no backpressure). That cycle is the one right after
// the last busy cycle, or the one right after the accepting edge when busy stays low. Timer
// state sits in one synchronous RAM that is read, updated and written back one entry at a
// time, in a read state and then a write-back state. A tick request walks every timer in
// turn, a start, stop or check on a valid timer touches only that timer, and a disabled
// tick, a bad timer_id or an unknown cmd finishes without raising busy. run_time shows the
// count after the request. tick_enable sits at APB byte address 0 and resets to 1.
module soft_timer_bank
  import stb_pkg::*;
#(
  parameter int NUM_TIMERS = DEF_NUM_TIMERS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [ID_W-1:0]     timer_id,
  input  logic [PERIOD_W-1:0] period,
  output logic                done,
  output logic                expired,
  output logic                id_error,
  output logic [RUN_W-1:0]    run_time,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic             tick_enable;
  stb_mem_req_t     mem_req;
  logic [IDX_W-1:0] mem_addr;
  stb_entry_t       mem_rdata;

  stb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .tick_enable (tick_enable)
  );

  stb_mem #(
    .NUM_TIMERS (NUM_TIMERS),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .addr  (mem_addr),
    .rdata (mem_rdata)
  );

  stb_ctrl #(
    .NUM_TIMERS (NUM_TIMERS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .tick_enable (tick_enable),
    .start       (start),
    .cmd         (cmd),
    .timer_id    (timer_id),
    .period      (period),
    .busy        (busy),
    .done        (done),
    .expired     (expired),
    .id_error    (id_error),
    .run_time    (run_time),
    .mem_req     (mem_req),
    .mem_addr    (mem_addr),
    .mem_rdata   (mem_rdata)
  );

endmodule
